// File: rtl/bms_pkg.sv
// ----------------------------------------------------------------------------
// Bread maker sequencer package
// Widths, register indexes, reset values, phase encoding and phase codes.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int STAMP_BITS_DEF = 32;
    localparam int TIME_W         = 18;
    localparam int SHOW_W         = 17;
    localparam int PHASE_W        = 4;
    localparam int TEMP_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int STEP_W         = 12;
    localparam int LOCKOUT_W      = 10;
    localparam int INTERVAL_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_DEFAULT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_DEFAULT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAKE_DEFAULT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOCKOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL = 3'd5;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] RST_MIX_DEFAULT   = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] RST_REST_DEFAULT  = 16'd5400;
    localparam logic [CFG_DATA_W-1:0] RST_BAKE_DEFAULT  = 16'd2400;
    localparam logic [STEP_W-1:0]     RST_TIME_STEP     = 12'd60;
    localparam logic [LOCKOUT_W-1:0]  RST_PRESS_LOCKOUT = 10'd10;
    localparam logic [INTERVAL_W-1:0] RST_TICK_INTERVAL = 16'd1000;

    localparam logic signed [TIME_W-1:0] TIME_MAX = 18'sd65535;

    localparam logic [TEMP_W-1:0] TEMP_RESET = 8'd152;
    localparam logic [TEMP_W-1:0] TEMP_COLD  = 8'd0;
    localparam logic [TEMP_W-1:0] TEMP_BAKE  = 8'd127;

    // Phase codes as seen on the result channel.
    localparam logic [PHASE_W-1:0] PC_OFF      = 4'd0;
    localparam logic [PHASE_W-1:0] PC_SET_MIX  = 4'd1;
    localparam logic [PHASE_W-1:0] PC_SET_REST = 4'd2;
    localparam logic [PHASE_W-1:0] PC_SET_BAKE = 4'd3;
    localparam logic [PHASE_W-1:0] PC_MIXING   = 4'd4;
    localparam logic [PHASE_W-1:0] PC_RESTING  = 4'd5;
    localparam logic [PHASE_W-1:0] PC_BAKING   = 4'd6;
    localparam logic [PHASE_W-1:0] PC_DONE     = 4'd7;
    localparam logic [PHASE_W-1:0] PC_READY    = 4'd8;

    // Button positions in the level vector.
    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_OK   = 2;

    typedef enum logic [8:0] {
        PH_OFF      = 9'b0_0000_0001,
        PH_SET_MIX  = 9'b0_0000_0010,
        PH_SET_REST = 9'b0_0000_0100,
        PH_SET_BAKE = 9'b0_0000_1000,
        PH_MIXING   = 9'b0_0001_0000,
        PH_RESTING  = 9'b0_0010_0000,
        PH_BAKING   = 9'b0_0100_0000,
        PH_DONE     = 9'b0_1000_0000,
        PH_READY    = 9'b1_0000_0000
    } t_phase;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_OFF:      code = PC_OFF;
            PH_SET_MIX:  code = PC_SET_MIX;
            PH_SET_REST: code = PC_SET_REST;
            PH_SET_BAKE: code = PC_SET_BAKE;
            PH_MIXING:   code = PC_MIXING;
            PH_RESTING:  code = PC_RESTING;
            PH_BAKING:   code = PC_BAKING;
            PH_DONE:     code = PC_DONE;
            PH_READY:    code = PC_READY;
            default:     code = PC_OFF;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/bms_in_if.sv
// ----------------------------------------------------------------------------
// Bread maker sequencer sample channel
// Valid/ready channel carrying one timestamped sample of the three buttons.
// ----------------------------------------------------------------------------
interface bms_in_if #(
    parameter int STAMP_BITS = bms_pkg::STAMP_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [STAMP_BITS-1:0] now_ms;
    logic                  up_level;
    logic                  down_level;
    logic                  ok_level;

    modport source (output valid, output now_ms, output up_level, output down_level,
                    output ok_level, input ready);
    modport sink   (input valid, input now_ms, input up_level, input down_level,
                    input ok_level, output ready);
endinterface

// File: rtl/bms_out_if.sv
// ----------------------------------------------------------------------------
// Bread maker sequencer result channel
// Valid/ready channel carrying the phase, drives and display data of a sample.
// ----------------------------------------------------------------------------
interface bms_out_if;
    logic                                valid;
    logic                                ready;
    logic [bms_pkg::PHASE_W-1:0]         phase;
    logic                                motor_on;
    logic                                heater_on;
    logic                                show_valid;
    logic signed [bms_pkg::SHOW_W-1:0]   show_time;
    logic                                show_degrees;
    logic [bms_pkg::TEMP_W-1:0]          temperature;
    logic                                finished;

    modport source (output valid, output phase, output motor_on, output heater_on,
                    output show_valid, output show_time, output show_degrees,
                    output temperature, output finished, input ready);
    modport sink   (input valid, input phase, input motor_on, input heater_on,
                    input show_valid, input show_time, input show_degrees,
                    input temperature, input finished, output ready);
endinterface

// File: rtl/bread_maker_sequencer_top.sv
// ----------------------------------------------------------------------------
// Bread maker sequencer
// Button-driven time setting and mix, rest, bake run sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one beat per sample: a millisecond timestamp and the
//   active-low levels of the Up, Down and OK buttons. o_result returns one
//   beat per sample with the phase after the update, the motor and heater
//   drives, the display value and the temperature figure.
//   The configuration port writes register i_cfg_index with i_cfg_data at a
//   clock edge with i_cfg_we high; write it only while no sample is in flight.
//   A default time write loads that time only while the block is ready.
//   A sample passes the input register, which loads at the accepting edge,
//   and then the result register, which loads together with the state update
//   when results are taken. One sample is accepted every cycle as long as
//   results are taken; the whole update is one pass of compares and adds
//   behind the input register.
//   When the receiver stalls, the result register holds and the input
//   register takes one more beat before i_sample.ready drops.
//   Reset (synchronous, active low) empties both registers, returns to the
//   ready phase and restores all registers and times to their defaults.
// ----------------------------------------------------------------------------
module bread_maker_sequencer_top #(
    parameter int STAMP_BITS = bms_pkg::STAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bms_in_if.sink                           i_sample,
    bms_out_if.source                        o_result
);

    localparam int TW = bms_pkg::TIME_W;

    // Configuration registers.
    logic [bms_pkg::STEP_W-1:0]     r_time_step;
    logic [bms_pkg::LOCKOUT_W-1:0]  r_lockout;
    logic [bms_pkg::INTERVAL_W-1:0] r_interval;

    // Input register.
    logic                  r_in_valid;
    logic [STAMP_BITS-1:0] r_in_now;
    logic [2:0]            r_in_levels;

    // Sequencer state.
    bms_pkg::t_phase        r_phase, n_phase;
    logic signed [TW-1:0]   r_times [3];
    logic signed [TW-1:0]   n_times [3];
    logic [bms_pkg::TEMP_W-1:0] r_temp, n_temp;
    logic [2:0]             r_prev_levels;
    logic [STAMP_BITS-1:0]  r_press_stamp [3];
    logic [STAMP_BITS-1:0]  n_press_stamp [3];
    logic [STAMP_BITS-1:0]  r_phase_stamp [3];
    logic [STAMP_BITS-1:0]  n_phase_stamp [3];

    // Result register.
    logic                           r_out_valid;
    logic [bms_pkg::PHASE_W-1:0]    r_out_phase;
    logic                           r_out_motor;
    logic                           r_out_heater;
    logic                           r_out_show;
    logic signed [bms_pkg::SHOW_W-1:0] r_out_time;
    logic                           r_out_degrees;
    logic [bms_pkg::TEMP_W-1:0]     r_out_temp;
    logic                           r_out_finished;

    logic advance;
    logic proc;

    assign advance        = !r_out_valid || o_result.ready;
    assign proc           = r_in_valid && advance;
    assign i_sample.ready = !r_in_valid || advance;

    // Button presses: falling edge outside the lockout window.
    logic [2:0]            press;
    logic [STAMP_BITS-1:0] press_age [3];
    always_comb begin
        for (int b = 0; b < 3; b++) begin
            press_age[b] = r_in_now - r_press_stamp[b];
            press[b] = r_prev_levels[b] && !r_in_levels[b] &&
                       (press_age[b] > {{(STAMP_BITS-bms_pkg::LOCKOUT_W){1'b0}}, r_lockout});
        end
    end

    // Time slot used by the current phase, and the slot shown after OK.
    logic [1:0] sel_k;
    logic [1:0] sel_next;
    always_comb begin
        case (r_phase)
            bms_pkg::PH_SET_MIX,  bms_pkg::PH_MIXING:  begin sel_k = 2'd0; sel_next = 2'd1; end
            bms_pkg::PH_SET_REST, bms_pkg::PH_RESTING: begin sel_k = 2'd1; sel_next = 2'd2; end
            bms_pkg::PH_SET_BAKE, bms_pkg::PH_BAKING:  begin sel_k = 2'd2; sel_next = 2'd0; end
            default:                                   begin sel_k = 2'd0; sel_next = 2'd0; end
        endcase
    end

    logic signed [TW-1:0]  cur_time;
    logic signed [TW-1:0]  step_s;
    logic signed [TW-1:0]  up_sum;
    logic signed [TW-1:0]  t_up;
    logic signed [TW-1:0]  t_dn;
    logic signed [TW-1:0]  t_tick;
    logic [STAMP_BITS-1:0] tick_age;
    logic                  tick_due;

    assign cur_time = r_times[sel_k];
    assign step_s   = $signed({{(TW-bms_pkg::STEP_W){1'b0}}, r_time_step});
    assign up_sum   = cur_time + step_s;
    assign t_up     = press[bms_pkg::BTN_UP]
                    ? ((up_sum > bms_pkg::TIME_MAX) ? bms_pkg::TIME_MAX : up_sum) : cur_time;
    assign t_dn     = (press[bms_pkg::BTN_DOWN] && (t_up > 0)) ? (t_up - step_s) : t_up;
    assign t_tick   = cur_time - step_s;
    assign tick_age = r_in_now - r_phase_stamp[sel_k];
    assign tick_due = tick_age > {{(STAMP_BITS-bms_pkg::INTERVAL_W){1'b0}}, r_interval};

    logic                 show;
    logic                 degrees;
    logic                 finished;
    logic signed [TW-1:0] shown;

    always_comb begin
        n_phase       = r_phase;
        n_times       = r_times;
        n_temp        = r_temp;
        n_press_stamp = r_press_stamp;
        n_phase_stamp = r_phase_stamp;
        show          = 1'b0;
        degrees       = 1'b0;
        finished      = 1'b0;
        shown         = '0;
        case (r_phase)
            bms_pkg::PH_READY: begin
                if (press[bms_pkg::BTN_OK]) begin
                    n_press_stamp[bms_pkg::BTN_OK] = r_in_now;
                    n_phase = bms_pkg::PH_SET_MIX;
                    show    = 1'b1;
                    shown   = r_times[0];
                end
            end
            bms_pkg::PH_SET_MIX, bms_pkg::PH_SET_REST, bms_pkg::PH_SET_BAKE: begin
                if (press[bms_pkg::BTN_UP]) begin
                    n_press_stamp[bms_pkg::BTN_UP] = r_in_now;
                end
                if (press[bms_pkg::BTN_DOWN]) begin
                    n_press_stamp[bms_pkg::BTN_DOWN] = r_in_now;
                end
                n_times[sel_k] = t_dn;
                if (press[bms_pkg::BTN_UP] || press[bms_pkg::BTN_DOWN]) begin
                    show  = 1'b1;
                    shown = t_dn;
                end
                // OK shows the time of the phase that follows.
                if (press[bms_pkg::BTN_OK]) begin
                    n_press_stamp[bms_pkg::BTN_OK] = r_in_now;
                    show  = 1'b1;
                    shown = r_times[sel_next];
                    case (r_phase)
                        bms_pkg::PH_SET_MIX:  n_phase = bms_pkg::PH_SET_REST;
                        bms_pkg::PH_SET_REST: n_phase = bms_pkg::PH_SET_BAKE;
                        default: begin
                            n_phase = bms_pkg::PH_MIXING;
                            n_temp  = bms_pkg::TEMP_COLD;
                        end
                    endcase
                end
            end
            bms_pkg::PH_MIXING, bms_pkg::PH_RESTING, bms_pkg::PH_BAKING: begin
                if (tick_due) begin
                    n_phase_stamp[sel_k] = r_in_now;
                    n_times[sel_k]       = t_tick;
                    show    = 1'b1;
                    degrees = 1'b1;
                    shown   = cur_time;
                    if (t_tick < 0) begin
                        case (r_phase)
                            bms_pkg::PH_MIXING: begin
                                n_phase = bms_pkg::PH_RESTING;
                                n_temp  = bms_pkg::TEMP_COLD;
                            end
                            bms_pkg::PH_RESTING: begin
                                n_phase = bms_pkg::PH_BAKING;
                                n_temp  = bms_pkg::TEMP_BAKE;
                            end
                            default: n_phase = bms_pkg::PH_DONE;
                        endcase
                    end
                end
            end
            bms_pkg::PH_DONE: begin
                n_phase  = bms_pkg::PH_OFF;
                finished = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
        if (i_sample.valid && i_sample.ready) begin
            r_in_now    <= i_sample.now_ms;
            r_in_levels <= {i_sample.ok_level, i_sample.down_level, i_sample.up_level};
        end
    end

    // Configuration and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= bms_pkg::RST_TIME_STEP;
            r_lockout     <= bms_pkg::RST_PRESS_LOCKOUT;
            r_interval    <= bms_pkg::RST_TICK_INTERVAL;
            r_phase       <= bms_pkg::PH_READY;
            r_times[0]    <= $signed({{(TW-bms_pkg::CFG_DATA_W){1'b0}}, bms_pkg::RST_MIX_DEFAULT});
            r_times[1]    <= $signed({{(TW-bms_pkg::CFG_DATA_W){1'b0}}, bms_pkg::RST_REST_DEFAULT});
            r_times[2]    <= $signed({{(TW-bms_pkg::CFG_DATA_W){1'b0}}, bms_pkg::RST_BAKE_DEFAULT});
            r_temp        <= bms_pkg::TEMP_RESET;
            r_prev_levels <= 3'b111;
            for (int i = 0; i < 3; i++) begin
                r_press_stamp[i] <= '0;
                r_phase_stamp[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bms_pkg::CFG_MIX_DEFAULT, bms_pkg::CFG_REST_DEFAULT,
                    bms_pkg::CFG_BAKE_DEFAULT: begin
                        // The default only matters as the time it loads while ready.
                        if (r_phase == bms_pkg::PH_READY) begin
                            r_times[i_cfg_index[1:0]] <=
                                $signed({{(TW-bms_pkg::CFG_DATA_W){1'b0}}, i_cfg_data});
                        end
                    end
                    bms_pkg::CFG_TIME_STEP:     r_time_step <= i_cfg_data[bms_pkg::STEP_W-1:0];
                    bms_pkg::CFG_PRESS_LOCKOUT: r_lockout   <= i_cfg_data[bms_pkg::LOCKOUT_W-1:0];
                    bms_pkg::CFG_TICK_INTERVAL: r_interval  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (proc) begin
                r_phase       <= n_phase;
                r_times       <= n_times;
                r_temp        <= n_temp;
                r_prev_levels <= r_in_levels;
                r_press_stamp <= n_press_stamp;
                r_phase_stamp <= n_phase_stamp;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (proc) begin
            r_out_phase    <= bms_pkg::phase_code(n_phase);
            r_out_motor    <= (n_phase == bms_pkg::PH_MIXING);
            r_out_heater   <= (n_phase == bms_pkg::PH_BAKING);
            r_out_show     <= show;
            r_out_time     <= shown[bms_pkg::SHOW_W-1:0];
            r_out_degrees  <= degrees;
            r_out_temp     <= n_temp;
            r_out_finished <= finished;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.phase        = r_out_phase;
    assign o_result.motor_on     = r_out_motor;
    assign o_result.heater_on    = r_out_heater;
    assign o_result.show_valid   = r_out_show;
    assign o_result.show_time    = r_out_time;
    assign o_result.show_degrees = r_out_degrees;
    assign o_result.temperature  = r_out_temp;
    assign o_result.finished     = r_out_finished;

endmodule
